FILE: sv/sensor_word_crc_check_convert_core_defines.svh
// assertion macros used by the checker file
`ifndef SENSOR_WORD_CRC_CHECK_CONVERT_CORE_DEFINES_SVH
`define SENSOR_WORD_CRC_CHECK_CONVERT_CORE_DEFINES_SVH

// property checked at every clock edge outside reset
`define SWCC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define SWCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/swcc_pkg.sv
`timescale 1ns / 1ps

package swcc_pkg;

   localparam logic [7:0]         CRC_POLY       = 8'h31;
   localparam logic [15:0]        STATUS_MASK    = 16'hFFFC;

   localparam logic [14:0]        TEMP_SCALE     = 15'd17572;
   localparam logic signed [16:0] TEMP_OFFSET    = -17'sd4685;
   localparam logic [14:0]        HUMID_SCALE    = 15'd12500;
   localparam logic signed [16:0] HUMID_OFFSET   = -17'sd600;

   localparam logic [1:0]         MODE_RAW       = 2'd0;
   localparam logic [1:0]         MODE_TEMP      = 2'd1;
   localparam logic [1:0]         MODE_HUMID     = 2'd2;

   localparam logic [1:0]         REG_CRC_START  = 2'd0;
   localparam logic [1:0]         REG_CONV_MODE  = 2'd1;
   localparam logic [1:0]         REG_WORDS      = 2'd2;

   localparam logic [7:0]         CRC_START_RST  = 8'hFF;
   localparam logic [1:0]         CONV_MODE_RST  = MODE_RAW;
   localparam logic [1:0]         WORDS_RST      = 2'd1;

   localparam logic [1:0]         POS_HIGH       = 2'd0;
   localparam logic [1:0]         POS_LOW        = 2'd1;

   localparam int                 CSR_ADDR_W     = 4;
   localparam int                 CSR_DATA_W     = 32;

   // msb-first crc-8 over one byte, no final xor
   function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (r[7]) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

FILE: sv/swcc_ifs.sv
`timescale 1ns / 1ps

interface swcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface swcc_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        raw_word;
   logic signed [16:0] converted_value;
   logic               crc_good;
   logic               word_index;
   logic               frame_last;

   modport source (output valid, output raw_word, output converted_value, output crc_good,
                   output word_index, output frame_last, input ready);
   modport sink (input valid, input raw_word, input converted_value, input crc_good,
                 input word_index, input frame_last, output ready);
endinterface

FILE: sv/swcc_convert.sv
`timescale 1ns / 1ps

module swcc_convert (
   input  logic [15:0]        raw_word,
   input  logic [1:0]         mode,
   output logic signed [16:0] value
);
   import swcc_pkg::*;

   logic [15:0]        code;
   logic [14:0]        coeff;
   logic signed [16:0] offset;
   logic [30:0]        product;
   logic [14:0]        scaled;

   always_comb begin
      code = raw_word & STATUS_MASK;
      case (mode)
         MODE_TEMP: begin
            coeff  = TEMP_SCALE;
            offset = TEMP_OFFSET;
         end
         MODE_HUMID: begin
            coeff  = HUMID_SCALE;
            offset = HUMID_OFFSET;
         end
         default: begin
            coeff  = '0;
            offset = '0;
         end
      endcase
      product = {16'd0, coeff} * {15'd0, code};
      scaled  = product[30:16];
      if (mode == MODE_TEMP || mode == MODE_HUMID) begin
         value = offset + $signed({2'b00, scaled});
      end else begin
         value = $signed({1'b0, raw_word});
      end
   end

endmodule

FILE: sv/sensor_word_crc_check_convert_core.sv
`timescale 1ns / 1ps

// Sensor word CRC check and conversion. Takes one reply byte per cycle on req_ch and gives
// one result per three-byte word (high, low, crc) on rsp_ch, in the cycle after the crc byte is
// taken: the raw word, the converted value (raw, centidegrees or centipercent), the crc flag,
// the word's place in the reply and a last-word flag. The value is given whether or not the
// crc matches. One byte is taken every cycle; a single output register holds the result, so
// req_ch.ready drops only while that register holds a result that rsp_ch has not taken.
// Registers on the csr port: 0x0 crc start value, 0x4 conversion mode, 0x8 words per reply.
module sensor_word_crc_check_convert_core (
   input  logic                              clock,
   input  logic                              reset,
   swcc_req_if.sink                          req_ch,
   swcc_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [swcc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [swcc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [swcc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import swcc_pkg::*;

   logic [7:0]         crc_start_ff;
   logic [1:0]         conv_mode_ff;
   logic [1:0]         words_ff;

   logic [7:0]         crc_acc_ff, crc_acc_in;
   logic [1:0]         pos_ff, pos_in;
   logic [7:0]         high_ff, high_in;
   logic [7:0]         low_ff, low_in;
   logic               wc_ff, wc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_raw_ff;
   logic signed [16:0] rsp_value_ff;
   logic               rsp_good_ff;
   logic               rsp_index_ff;
   logic               rsp_last_ff;

   logic               accept;
   logic               emit;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [1:0]         pos_eff;
   logic               wc_eff;
   logic               last;
   logic [15:0]        raw_word;
   logic signed [16:0] conv_value;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_start_ff <= CRC_START_RST;
         conv_mode_ff <= CONV_MODE_RST;
         words_ff     <= WORDS_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_CRC_START: crc_start_ff <= csr_pwdata[7:0];
            REG_CONV_MODE: conv_mode_ff <= csr_pwdata[1:0];
            REG_WORDS:     words_ff     <= csr_pwdata[1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CRC_START: csr_prdata = {24'd0, crc_start_ff};
         REG_CONV_MODE: csr_prdata = {30'd0, conv_mode_ff};
         REG_WORDS:     csr_prdata = {30'd0, words_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign raw_word     = {high_ff, low_ff};

   swcc_convert u_convert (
      .raw_word (raw_word),
      .mode     (conv_mode_ff),
      .value    (conv_value)
   );

   always_comb begin
      pos_eff    = req_ch.frame_start ? POS_HIGH : pos_ff;
      wc_eff     = req_ch.frame_start ? 1'b0 : wc_ff;
      // two words only when the register asks for two or three
      last       = wc_eff || !words_ff[1];
      emit       = 1'b0;
      crc_acc_in = crc_acc_ff;
      pos_in     = pos_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      wc_in      = wc_ff;
      if (accept) begin
         case (pos_eff)
            POS_HIGH: begin
               high_in    = req_ch.data_byte;
               crc_acc_in = crc8_update(crc_start_ff, req_ch.data_byte);
               pos_in     = POS_LOW;
               wc_in      = wc_eff;
            end
            POS_LOW: begin
               low_in     = req_ch.data_byte;
               crc_acc_in = crc8_update(crc_acc_ff, req_ch.data_byte);
               pos_in     = pos_ff + 2'd1;
            end
            default: begin
               emit       = 1'b1;
               crc_acc_in = crc_start_ff;
               pos_in     = POS_HIGH;
               wc_in      = last ? 1'b0 : 1'b1;
            end
         endcase
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_acc_ff   <= CRC_START_RST;
         pos_ff       <= POS_HIGH;
         high_ff      <= '0;
         low_ff       <= '0;
         wc_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_acc_ff   <= crc_acc_in;
         pos_ff       <= pos_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         wc_ff        <= wc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_raw_ff   <= raw_word;
         rsp_value_ff <= conv_value;
         rsp_good_ff  <= (crc_acc_ff == req_ch.data_byte);
         rsp_index_ff <= wc_eff;
         rsp_last_ff  <= last;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.raw_word        = rsp_raw_ff;
   assign rsp_ch.converted_value = rsp_value_ff;
   assign rsp_ch.crc_good        = rsp_good_ff;
   assign rsp_ch.word_index      = rsp_index_ff;
   assign rsp_ch.frame_last      = rsp_last_ff;

endmodule

FILE: sv/swcc_checker.sv
`timescale 1ns / 1ps
`include "sensor_word_crc_check_convert_core_defines.svh"

module swcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_raw_word,
   input logic        rsp_word_index,
   input logic        rsp_frame_last,
   input logic        csr_pready
);

   // a waiting result blocks new bytes
   `SWCC_ASSERT(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready |-> !req_ready, "req ready while result stalled")

   // a new result needs a byte taken the cycle before
   `SWCC_ASSERT(a_rsp_from_req, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready), "result without item")

   // second word of a reply is always its last
   `SWCC_ASSERT(a_second_is_last, clock, reset, rsp_valid && rsp_word_index |-> rsp_frame_last, "second word not last")

   `SWCC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_raw_word), "stalled result changed")

   `SWCC_ASSERT_ALWAYS(a_pready_high, clock, csr_pready, "csr pready low")

endmodule

bind sensor_word_crc_check_convert_core swcc_checker u_swcc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_raw_word   (rsp_ch.raw_word),
   .rsp_word_index (rsp_ch.word_index),
   .rsp_frame_last (rsp_ch.frame_last),
   .csr_pready     (csr_pready)
);
